/* rtl/cjtp_pkg.sv */
// Shared types and constants for the cubic joint trajectory player.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package cjtp_pkg;
    localparam int ANGLE_W = 8;
    localparam int TICK_W = 16;
    localparam int OUT_W = 16;
    localparam logic [ANGLE_W-1:0] ANGLE_HOME = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
    localparam int NUM_W = 16;   // weight quotient bits; below 65536 while moving
    localparam int DEN_W = 48;   // T^3

    // run modes
    typedef enum logic [1:0] {
        MODE_DIRECT  = 2'd0,
        MODE_LOADING = 2'd1,
        MODE_PLAYING = 2'd2
    } t_mode;

    // controller -> datapath
    typedef struct packed {
        logic calc_start;   // begin weight computation
        logic blend_start;  // begin joint blending
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic calc_done;
        logic blend_done;
    } t_sts;

    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [9:0] v);
        logic [ANGLE_W-1:0] r;
        if (v < 0) r = '0;
        else if (v > 10'sd180) r = ANGLE_MAX;
        else r = v[ANGLE_W-1:0];
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/cjtp_ram.sv */
// Generic single-port write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cjtp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/cjtp_datapath.sv */
// Blend datapath: cubic weight (multiply, restoring divide) and joint blending.
// Depends on cjtp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cjtp_datapath
    import cjtp_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd                          i_cmd,
    input  wire logic [TICK_W-1:0]             i_elapsed,
    input  wire logic [TICK_W-1:0]             i_ticks,
    input  wire logic [3*ANGLE_W-1:0]          i_start,
    input  wire logic [3*ANGLE_W-1:0]          i_target,
    output t_sts                               o_sts,
    output logic [3*OUT_W-1:0]                 o_angles
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_MUL = 5'b00010, S_DIV = 5'b00100,
        S_BLEND = 5'b01000, S_DONE = 5'b10000
    } t_dstate;

    t_dstate r_state, n_state;
    logic [2:0] r_step;                 // multiply step
    logic [5:0] r_bit;                  // divide bit count
    logic [1:0] r_joint;
    logic [NUM_W-1:0] r_num;            // quotient shifter
    logic [DEN_W:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_prod;
    logic [16:0] r_w;                   // weight 0..65535
    logic [3*OUT_W-1:0] r_out;

    // shared multiplier: 32x18 per step
    logic [31:0] mul_a;
    logic [17:0] mul_b;
    logic [49:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [TICK_W+1:0] three_t_m2e;
    assign three_t_m2e = 18'(3 * {2'b0, i_ticks}) - 18'({i_elapsed, 1'b0});

    logic [ANGLE_W-1:0] js, jt, jd;
    assign js = i_start[r_joint*ANGLE_W +: ANGLE_W];
    assign jt = i_target[r_joint*ANGLE_W +: ANGLE_W];
    assign jd = (jt >= js) ? jt - js : js - jt;

    always_comb begin
        mul_a = '0; mul_b = '0;
        case (r_step)
            3'd0: begin mul_a = 32'(i_elapsed); mul_b = 18'(i_elapsed); end
            3'd1: begin mul_a = r_prod[31:0]; mul_b = three_t_m2e; end
            3'd2: begin mul_a = 32'(i_ticks); mul_b = 18'(i_ticks); end
            3'd3: begin mul_a = r_prod[31:0]; mul_b = 18'(i_ticks); end
            3'd4: begin mul_a = 32'(jd); mul_b = 18'(r_w); end
            default: ;
        endcase
    end

    logic [DEN_W:0] rem_sh;
    logic [OUT_W+ANGLE_FRAC_BITS+8:0] mag;
    logic [OUT_W-1:0] jres;
    // remainder starts at the numerator (below T^3); 16 zero bits shift in
    assign rem_sh = {r_rem[DEN_W-1:0], 1'b0};
    assign mag = ((($bits(mag))'(mul_p[24:0]) << ANGLE_FRAC_BITS) + 32768) >> 16;
    always_comb begin
        logic [OUT_W-1:0] base;
        base = OUT_W'(32'(js) << ANGLE_FRAC_BITS);
        jres = (jt >= js) ? base + OUT_W'(mag) : base - OUT_W'(mag);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_cmd.calc_start) n_state = S_MUL;
                     else if (i_cmd.blend_start) n_state = S_BLEND;
            S_MUL:   if (r_step == 3'd3) n_state = S_DIV;
            S_DIV:   if (r_bit == 6'(NUM_W - 1)) n_state = S_DONE;
            S_BLEND: if (r_joint == 2'd2) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_step <= i_cmd.calc_start ? 3'd0 : 3'd4;
                r_joint <= '0;
                r_bit <= '0;
                r_rem <= '0;
            end
            S_MUL: begin
                // step count stays at 3 so that done means a weight
                r_step <= (r_step == 3'd3) ? r_step : r_step + 3'd1;
                r_prod <= mul_p[DEN_W-1:0];
                if (r_step == 3'd1) begin
                    r_rem <= {1'b0, mul_p[DEN_W-1:0]};
                    r_num <= '0;
                end
                if (r_step == 3'd3) r_den <= mul_p[DEN_W-1:0];
            end
            S_DIV: begin
                r_bit <= r_bit + 6'd1;
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= rem_sh - {1'b0, r_den};
                    r_num <= {r_num[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                end
            end
            S_BLEND: begin
                r_joint <= r_joint + 2'd1;
                r_out[r_joint*OUT_W +: OUT_W] <= jres;
            end
            default: ;
        endcase
        if (r_state == S_DONE && r_step != 3'd4) r_w <= 17'(r_num);
    end

    assign o_sts.calc_done  = (r_state == S_DONE) && (r_step != 3'd4);
    assign o_sts.blend_done = (r_state == S_DONE) && (r_step == 3'd4);
    assign o_angles = r_out;
endmodule
`default_nettype wire

/* rtl/cjtp_ctrl.sv */
// Controller: command decoding, mode sequencing, waypoint store and output handshake.
// Depends on cjtp_pkg and cjtp_ram.
`timescale 1ns / 1ps
`default_nettype none
module cjtp_ctrl
    import cjtp_pkg::*;
#(
    parameter int WAYPOINTS = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [TICK_W-1:0]    i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [25:0]          i_item,     // action, first, second, third
    output logic                      o_valid,
    input  wire logic                 i_out_ready,
    output logic [3*OUT_W:0]          o_result,   // elbow, shoulder, base, in_motion
    output t_cmd                      o_cmd,
    input  wire t_sts                 i_sts,
    output logic [TICK_W-1:0]         o_elapsed,
    output logic [TICK_W-1:0]         o_ticks,
    output logic [3*ANGLE_W-1:0]      o_start,
    output logic [3*ANGLE_W-1:0]      o_target,
    input  wire logic [3*OUT_W-1:0]   i_angles
);
    localparam int IW = (WAYPOINTS > 1) ? $clog2(WAYPOINTS) : 1;
    localparam int CW = $clog2(WAYPOINTS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_CMD = 6'b000010, S_CALC = 6'b000100,
        S_BLEND = 6'b001000, S_HOLD = 6'b010000, S_OUT = 6'b100000
    } t_state;

    t_state r_state;
    t_mode r_mode;
    logic [TICK_W-1:0] r_ticks, r_elapsed;
    logic [3*ANGLE_W-1:0] r_start, r_target;
    logic [CW-1:0] r_left, r_total;
    logic [IW-1:0] r_play;
    logic [25:0] r_item;
    logic r_valid, r_wait;
    logic [3*OUT_W:0] r_res;

    logic signed [8:0] first;
    logic [3*ANGLE_W-1:0] goal;
    logic [CW-1:0] hdr_n;
    assign first = r_item[24:16];
    assign goal = {clamp_angle(10'(r_item[7:0])), clamp_angle(10'(r_item[15:8])),
                   clamp_angle(10'(first))};
    always_comb begin
        if (r_item[7:0] == 8'd0) hdr_n = CW'(1);
        else if (32'(r_item[7:0]) > WAYPOINTS) hdr_n = CW'(WAYPOINTS);
        else hdr_n = CW'(r_item[7:0]);
    end

    // waypoint store
    logic ram_we;
    logic [IW-1:0] ram_wa, ram_ra;
    logic [3*ANGLE_W-1:0] ram_rd;
    cjtp_ram #(.WIDTH(3*ANGLE_W), .DEPTH(WAYPOINTS)) u_store (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(goal),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    logic [IW-1:0] next_play;
    assign next_play = (32'(r_play) + 1 >= 32'(r_total)) ? '0 : r_play + IW'(1);
    assign ram_we = (r_state == S_CMD) && r_item[25] && (r_mode == MODE_LOADING)
                    && (first != -9'sd1) && (32'(r_total) < WAYPOINTS);
    assign ram_wa = r_total[IW-1:0];
    // first waypoint is read in the cycle after the last one is written
    assign ram_ra = r_wait ? '0 : next_play;

    assign o_ready = (r_state == S_IDLE) && !r_wait;
    assign o_cmd.calc_start = (r_state == S_CALC) && !r_valid;
    assign o_cmd.blend_start = (r_state == S_BLEND) && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_mode <= MODE_DIRECT;
            r_ticks <= 16'd100; r_elapsed <= 16'd100;
            r_start <= {3{ANGLE_HOME}}; r_target <= {3{ANGLE_HOME}};
            r_left <= '0; r_total <= '0; r_play <= '0;
            r_valid <= 1'b0; r_wait <= 1'b0;
        end else begin
            if (i_cfg_we) r_ticks <= i_cfg_data;
            if (r_valid && i_out_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (r_wait) begin
                        // program loaded: first waypoint read now in flight
                        r_wait <= 1'b0;
                        r_state <= S_HOLD;
                    end else if (i_valid && o_ready) begin
                        r_item <= i_item;
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    if (!r_item[25]) begin
                        r_state <= (r_elapsed >= r_ticks) ? S_OUT : S_CALC;
                    end else begin
                        r_state <= S_IDLE;
                        if (r_mode == MODE_PLAYING) begin
                            // commands are ignored during playback
                        end else if (first == -9'sd1) begin
                            r_mode <= MODE_LOADING; r_left <= hdr_n; r_total <= '0;
                        end else if (r_mode == MODE_LOADING) begin
                            if (ram_we) r_total <= r_total + CW'(1);
                            if (r_left <= CW'(1)) begin
                                r_left <= '0; r_mode <= MODE_PLAYING; r_play <= '0;
                                r_wait <= 1'b1;
                            end else r_left <= r_left - CW'(1);
                        end else begin
                            r_start <= r_target; r_target <= goal; r_elapsed <= '0;
                        end
                    end
                end
                S_HOLD: begin
                    // store read data now valid: start the new segment
                    r_start <= r_target; r_target <= ram_rd; r_elapsed <= '0;
                    r_state <= S_IDLE;
                end
                S_CALC: if (i_sts.calc_done) r_state <= S_BLEND;
                S_BLEND: if (i_sts.blend_done) begin
                    r_res <= {i_angles, 1'b1};
                    r_valid <= 1'b1;
                    if (r_elapsed != 16'hFFFF) r_elapsed <= r_elapsed + 16'd1;
                    r_state <= S_IDLE;
                end
                S_OUT: if (!r_valid) begin
                    r_res <= {OUT_W'(32'(r_target[23:16]) << ANGLE_FRAC_BITS),
                              OUT_W'(32'(r_target[15:8]) << ANGLE_FRAC_BITS),
                              OUT_W'(32'(r_target[7:0]) << ANGLE_FRAC_BITS), 1'b0};
                    r_valid <= 1'b1;
                    if (r_mode == MODE_PLAYING && r_total != '0) begin
                        r_play <= next_play; r_state <= S_HOLD;
                    end else r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_result = r_res;
    assign o_elapsed = r_elapsed;
    assign o_ticks = r_ticks;
    assign o_start = r_start;
    assign o_target = r_target;
endmodule
`default_nettype wire

/* rtl/cubic_joint_trajectory_player.sv */
// Cubic joint trajectory player, top level: controller plus blend datapath.
// A command goes straight back to idle (a program end first starts its first segment); a tick that
// blends runs 4 multiply steps and 16 divide steps for the weight, then 3 joint steps, and offers
// its result; a settled tick gives the target angles (and in playback starts the next segment).
// The block takes one request at a time; a tick also waits while the previous result is stalled.
// Reset: synchronous active low; angles home at 90, move length 100, direct mode. Depends on
// cjtp_pkg, cjtp_ctrl, cjtp_datapath, cjtp_ram.
`timescale 1ns / 1ps
`default_nettype none
module cubic_joint_trajectory_player
    import cjtp_pkg::*;
#(
    parameter int WAYPOINTS = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_move_ticks_we,
    input  wire logic [15:0] i_move_ticks,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // cmd_first[8:0], cmd_second, cmd_third, pad
    input  wire logic        s_axis_tuser,  // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata   // base, shoulder, elbow, in_motion, pad
);
    t_cmd cmd;
    t_sts sts;
    logic [TICK_W-1:0] elapsed, ticks;
    logic [3*ANGLE_W-1:0] st, tg;
    logic [3*OUT_W-1:0] angles;
    logic [3*OUT_W:0] res;

    cjtp_ctrl #(.WAYPOINTS(WAYPOINTS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_move_ticks_we), .i_cfg_data(i_move_ticks),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item({s_axis_tuser, s_axis_tdata[8:0], s_axis_tdata[16:9], s_axis_tdata[24:17]}),
        .o_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .o_result(res),
        .o_cmd(cmd), .i_sts(sts), .o_elapsed(elapsed), .o_ticks(ticks),
        .o_start(st), .o_target(tg), .i_angles(angles)
    );

    cjtp_datapath #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_elapsed(elapsed),
        .i_ticks(ticks), .i_start(st), .i_target(tg), .o_sts(sts), .o_angles(angles)
    );

    assign m_axis_tdata = {7'd0, res[0], res[48:1]};

    // a delivered result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // no new request while the datapath is busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.calc_start || cmd.blend_start) |-> !s_axis_tready)
        else $error("input accepted during blend");
    // only one datapath command at a time
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.calc_start && cmd.blend_start))
        else $error("conflicting datapath commands");
endmodule
`default_nettype wire

/* tb/cubic_joint_trajectory_player_test.sv */
// Testbench for cubic_joint_trajectory_player: drives commands and ticks, predicts joint angles.
// Depends on cjtp_pkg and the cubic_joint_trajectory_player RTL.
`timescale 1ns / 1ps
`default_nettype none
module cubic_joint_trajectory_player_test;
    import cjtp_pkg::*;

    localparam int WP = 16;
    localparam int FRAC = 8;
    localparam int WATCHDOG = 5000;
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_CMD = 1'b1;
    localparam logic signed [8:0] HEADER_MARK = -9'sd1;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] shoulder;
        logic [15:0] elbow;
        logic        moving;
    } t_pose;

    // Joint pose predictor plus queue of expected tick results
    class pose_scoreboard;
        logic [15:0] move_len;
        logic [7:0]  from_ang[3];
        logic [7:0]  goal_ang[3];
        logic [15:0] elapsed;
        t_mode       mode;
        int          left_cnt, total_cnt, play_idx;
        logic [7:0]  wp_store[WP][3];
        t_pose       pending[$];
        int          errors;

        function void home();
            move_len = 16'd100;
            for (int j = 0; j < 3; j++) begin
                from_ang[j] = ANGLE_HOME;
                goal_ang[j] = ANGLE_HOME;
            end
            elapsed = move_len;
            mode = MODE_DIRECT;
            left_cnt = 0;
            total_cnt = 0;
            play_idx = 0;
            errors = 0;
        endfunction

        function logic [7:0] limit(int v);
            if (v < 0) return 8'd0;
            if (v > 180) return 8'd180;
            return v[7:0];
        endfunction

        function void start_move(logic [7:0] g0, logic [7:0] g1, logic [7:0] g2);
            for (int j = 0; j < 3; j++) from_ang[j] = goal_ang[j];
            goal_ang[0] = g0;
            goal_ang[1] = g1;
            goal_ang[2] = g2;
            elapsed = '0;
        endfunction

        function logic [15:0] blend(logic [7:0] s, logic [7:0] t, longint unsigned w);
            longint unsigned b, m;
            b = longint'(s) << FRAC;
            if (t >= s) begin
                m = (((longint'(t - s) * w) << FRAC) + 32768) >> 16;
                return 16'(b + m);
            end
            m = (((longint'(s - t) * w) << FRAC) + 32768) >> 16;
            return 16'(b - m);
        endfunction

        function void note_request(logic act, logic [31:0] d);
            logic signed [8:0] f;
            int n;
            logic [7:0] g[3];
            t_pose r;
            longint unsigned e, tt, w;
            f = d[8:0];
            if (act == ACT_CMD) begin
                if (mode == MODE_PLAYING) return;
                if (f == HEADER_MARK) begin
                    n = d[24:17];
                    if (n < 1) n = 1;
                    if (n > WP) n = WP;
                    mode = MODE_LOADING;
                    left_cnt = n;
                    total_cnt = 0;
                    return;
                end
                g[0] = limit(int'(f));
                g[1] = limit(int'(d[16:9]));
                g[2] = limit(int'(d[24:17]));
                if (mode == MODE_LOADING) begin
                    if (total_cnt < WP) begin
                        for (int j = 0; j < 3; j++) wp_store[total_cnt][j] = g[j];
                        total_cnt++;
                    end
                    if (left_cnt > 0) left_cnt--;
                    if (left_cnt == 0) begin
                        mode = MODE_PLAYING;
                        play_idx = 0;
                        start_move(wp_store[0][0], wp_store[0][1], wp_store[0][2]);
                    end
                    return;
                end
                start_move(g[0], g[1], g[2]);
                return;
            end
            if (elapsed >= move_len) begin
                r.base = 16'(goal_ang[0]) << FRAC;
                r.shoulder = 16'(goal_ang[1]) << FRAC;
                r.elbow = 16'(goal_ang[2]) << FRAC;
                r.moving = 1'b0;
                if (mode == MODE_PLAYING && total_cnt > 0) begin
                    play_idx++;
                    if (play_idx >= total_cnt) play_idx = 0;
                    start_move(wp_store[play_idx][0], wp_store[play_idx][1],
                        wp_store[play_idx][2]);
                end
            end else begin
                e = elapsed;
                tt = move_len;
                w = ((e * e * (3 * tt - 2 * e)) << 16) / (tt * tt * tt);
                r.base = blend(from_ang[0], goal_ang[0], w);
                r.shoulder = blend(from_ang[1], goal_ang[1], w);
                r.elbow = blend(from_ang[2], goal_ang[2], w);
                r.moving = 1'b1;
                if (elapsed < 16'hFFFF) elapsed++;
            end
            pending = {pending, r};
        endfunction

        function void check_result(logic [55:0] d);
            t_pose x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, d);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (d[15:0] !== x.base) begin
                $display("%0t: base exp %0d got %0d", $time, x.base, d[15:0]);
                errors++;
            end
            if (d[31:16] !== x.shoulder) begin
                $display("%0t: shoulder exp %0d got %0d", $time, x.shoulder, d[31:16]);
                errors++;
            end
            if (d[47:32] !== x.elbow) begin
                $display("%0t: elbow exp %0d got %0d", $time, x.elbow, d[47:32]);
                errors++;
            end
            if (d[48] !== x.moving) begin
                $display("%0t: in_motion exp %0b got %0b", $time, x.moving, d[48]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_move_ticks_we = 1'b0;
    logic [15:0] i_move_ticks = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // cmd_first[8:0], cmd_second, cmd_third, pad
    logic        s_axis_tuser = 1'b0; // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // base, shoulder, elbow, in_motion, pad

    pose_scoreboard sb;
    int idle_cnt = 0;
    bit stim_done = 1'b0;

    cubic_joint_trajectory_player uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_move_ticks_we(i_move_ticks_we), .i_move_ticks(i_move_ticks),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Sample both handshakes, check results, run the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WATCHDOG && !stim_done) begin
                $display("cubic_joint_trajectory_player_test NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random stall per result
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            gap = $urandom_range(0, 3);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // One request, with a random gap when asked
    task automatic send(logic act, logic signed [8:0] a, logic [7:0] b, logic [7:0] c,
                        bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {7'd0, c, b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Wait until results drain, then a settle margin
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_len(logic [15:0] v);
        i_move_ticks_we <= 1'b1;
        i_move_ticks <= v;
        @(posedge i_clk);
        i_move_ticks_we <= 1'b0;
        sb.move_len = v;
    endtask

    task automatic tick(bit gaps);
        send(ACT_TICK, 9'($urandom), 8'($urandom), 8'($urandom), gaps);
    endtask

    function automatic logic [7:0] rnd_ang();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 180));
    endfunction

    function automatic logic signed [8:0] rnd_first();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 9'($urandom);
        if (k == 1) return -9'sd1 - 9'($urandom_range(1, 255));
        return 9'($urandom_range(0, 180));
    endfunction

    initial begin
        int n;
        sb = new();
        sb.home();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, clamping, lengths zero and one, elapsed change
        tick(0);
        send(ACT_CMD, 9'sd180, 8'd0, 8'd255, 0);
        repeat (3) tick(0);
        send(ACT_CMD, 9'sd255, 8'd200, 8'd0, 0);
        send(ACT_CMD, -9'sd256, 8'd180, 8'd90, 0);
        repeat (2) tick(0);
        drain();
        set_len(16'd0);
        send(ACT_CMD, 9'sd10, 8'd170, 8'd45, 0);
        repeat (2) tick(0);
        drain();
        set_len(16'd1);
        send(ACT_CMD, 9'sd0, 8'd0, 8'd0, 0);
        repeat (3) tick(0);
        drain();
        set_len(16'd65535);
        send(ACT_CMD, 9'sd180, 8'd180, 8'd180, 0);
        repeat (3) tick(0);
        drain();
        set_len(16'd2);
        repeat (2) tick(0);
        drain();

        // Random direct mode across several move lengths
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_len(16'd3);
                1: set_len(16'($urandom_range(1, 40)));
                2: set_len(16'd65535);
                3: set_len(16'd0);
                4: set_len(16'($urandom_range(5, 20)));
                default: set_len(16'd100);
            endcase
            for (int i = 0; i < 140; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send(ACT_CMD, rnd_first(), rnd_ang(), rnd_ang(), 1);
                else
                    tick(1);
            end
            drain();
        end

        // Program load: aborted header, then a full program, then playback
        set_len(16'($urandom_range(1, 6)));
        send(ACT_CMD, HEADER_MARK, 8'($urandom), 8'd3, 1);
        send(ACT_CMD, rnd_first(), rnd_ang(), rnd_ang(), 1);
        tick(1);
        n = $urandom_range(0, 1) ? 0 : $urandom_range(17, 255);
        if ($urandom_range(0, 1)) n = $urandom_range(1, 16);
        send(ACT_CMD, HEADER_MARK, 8'($urandom), 8'(n), 1);
        n = (n < 1) ? 1 : (n > WP ? WP : n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) tick(1);
            send(ACT_CMD, rnd_first(), rnd_ang(), rnd_ang(), 1);
        end
        for (int i = 0; i < 200; i++) begin
            if ($urandom_range(0, 9) == 0)
                send(ACT_CMD, rnd_first(), rnd_ang(), rnd_ang(), 1);
            else
                tick(i > 60);
        end
        drain();
        set_len(16'd0);
        repeat (40) tick(1);
        drain();
        stim_done = 1'b1;

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("cubic_joint_trajectory_player_test OK");
        else
            $display("cubic_joint_trajectory_player_test NOT OK");
        $finish;
    end

    // Hard limit on the drain waits
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_cnt >= WATCHDOG && stim_done == 1'b0 && sb.pending.size() != 0) begin
                $display("cubic_joint_trajectory_player_test NOT OK");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
